/* hw/rtl/queue_level_random_early_drop_assert.svh */
// Assertion macros used by the checker file
`ifndef QUEUE_LEVEL_RANDOM_EARLY_DROP_ASSERT_SVH
`define QUEUE_LEVEL_RANDOM_EARLY_DROP_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define QRED_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define QRED_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/qred_pkg.sv */
package qred_pkg;

   localparam int THR_W      = 15;
   localparam int QLEN_W     = 16;
   localparam int CAP_W      = 16;
   localparam int SEED_W     = 32;
   localparam int DIG_W      = 2;
   localparam int DEC_W      = 2;
   localparam int OP_W       = 2;
   localparam int RAND_LSB   = 16;
   localparam int LOWER_SHIFT = 3;
   localparam int UPPER_SHIFT = 5;

   localparam logic [THR_W-1:0]  THR_MAX   = 15'h7FFF;
   localparam logic [SEED_W-1:0] LCG_MUL   = 32'd1103515245;
   localparam logic [SEED_W-1:0] LCG_ADD   = 32'd12345;
   localparam logic [SEED_W-1:0] SEED_INIT = 32'd123456789;

   localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
   localparam logic [OP_W-1:0] OP_RESET  = 2'd2;

   localparam logic [DEC_W-1:0] DEC_PASS = 2'd0;
   localparam logic [DEC_W-1:0] DEC_PROB = 2'd1;
   localparam logic [DEC_W-1:0] DEC_FULL = 2'd2;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic REG_QUEUE_CAPACITY = 1'b0;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [QLEN_W-1:0] queue_len;
   } req_word_type;

   typedef struct packed {
      logic [DEC_W-1:0] decision;
      logic [THR_W-1:0] drop_threshold;
      logic             drop_all;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_LCG,
      ST_FIN
   } state_type;

endpackage

/* hw/rtl/qred_div.sv */
module qred_div import qred_pkg::*; #(
   parameter int W = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [W+THR_W-1:0] num,
   input  logic [W-1:0]       den,
   output logic               done,
   output logic [THR_W-1:0]   quot
);

   localparam int STEPS = THR_W;
   localparam int CNT_W = $clog2(STEPS);

   logic [W-1:0]     rem_ff, rem_in;
   logic [THR_W-1:0] low_ff, low_in;
   logic [W-1:0]     den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [W:0]   trial;
   logic [W+1:0] diff;
   logic         fits;
   logic         last;

   always_comb begin
      trial = {rem_ff, low_ff[THR_W-1]};
      diff  = {1'b0, trial} - {2'b00, den_ff};
      fits  = !diff[W+1];
      last  = (cnt_ff == CNT_W'(STEPS-1));

      rem_in  = rem_ff;
      low_in  = low_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num[W+THR_W-1:THR_W];
         low_in  = num[THR_W-1:0];
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         rem_in = fits ? diff[W-1:0] : trial[W-1:0];
         low_in = {low_ff[THR_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = low_ff;

endmodule

/* hw/rtl/qred_lcg.sv */
module qred_lcg import qred_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SEED_W-1:0] seed,
   output logic              done,
   output logic [SEED_W-1:0] next_seed
);

   localparam int STEPS = SEED_W / DIG_W;
   localparam int CNT_W = $clog2(STEPS);

   logic [SEED_W-1:0] mc_ff, mc_in;
   logic [SEED_W-1:0] mc3_ff, mc3_in;
   logic [SEED_W-1:0] dig_ff, dig_in;
   logic [SEED_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [SEED_W-1:0] pp;
   logic              last;

   always_comb begin
      case (dig_ff[SEED_W-1 -: DIG_W])
         2'd0:    pp = '0;
         2'd1:    pp = mc_ff;
         2'd2:    pp = {mc_ff[SEED_W-2:0], 1'b0};
         default: pp = mc3_ff;
      endcase
      last = (cnt_ff == CNT_W'(STEPS-1));

      mc_in   = mc_ff;
      mc3_in  = mc3_ff;
      dig_in  = dig_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         mc_in   = seed;
         mc3_in  = seed + {seed[SEED_W-2:0], 1'b0};
         dig_in  = LCG_MUL;
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one multiplier digit per cycle, most significant first
         acc_in = {acc_ff[SEED_W-DIG_W-1:0], {DIG_W{1'b0}}} + pp
                  + (last ? LCG_ADD : '0);
         dig_in = {dig_ff[SEED_W-DIG_W-1:0], {DIG_W{1'b0}}};
         cnt_in = cnt_ff + CNT_W'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mc_ff  <= mc_in;
      mc3_ff <= mc3_in;
      dig_ff <= dig_in;
      acc_ff <= acc_in;
   end

   assign done      = done_ff;
   assign next_seed = acc_ff;

endmodule

/* hw/rtl/queue_level_random_early_drop.sv */
// Random early drop decider.
// req channel (valid/ready) takes one word: op and queue_len. Op update
// recomputes the drop threshold from queue_len and the capacity register,
// op query decides (drawing a random sample unless the full-drop flag is set),
// op reset clears the threshold and the full-drop flag. Every word yields
// one rsp word with decision, drop_threshold and full-drop flag.
// The capacity register is written over the APB port where paddr[2] is 0.
// One word is worked at a time. An update on the linear segment runs the
// 15-step serial divider, a query that draws a sample runs the 16-digit
// serial LCG multiplier; other words go from EXEC straight to FIN. The next
// word is taken once the result has been loaded into rsp.
// rsp is a register: a new word is accepted while a result waits, and
// its result is held back until the receiver takes the previous one.
// Reset clears the capacity, threshold and flag and loads the seed;
// the block is ready in the first cycle after reset.
module queue_level_random_early_drop import qred_pkg::*; #(
   parameter int QUEUE_LEN_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_word_type       req_word,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_word_type       rsp_word,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [CSR_AW-1:0]  paddr,
   input  logic [CSR_DW-1:0]  pwdata,
   output logic [CSR_DW-1:0]  prdata,
   output logic               pready
);

   localparam int LEN_W = (QUEUE_LEN_BITS < QLEN_W) ? QUEUE_LEN_BITS : QLEN_W;

   state_type state_ff, state_in;

   logic [CAP_W-1:0]  cap_ff;
   logic [OP_W-1:0]   op_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [THR_W-1:0]  thr_ff, thr_in;
   logic              flag_ff, flag_in;
   logic [SEED_W-1:0] seed_ff, seed_in;
   logic [DEC_W-1:0]  dec_ff, dec_in;
   logic              rsp_valid_ff;
   rsp_word_type      rsp_word_ff;

   logic [LEN_W-1:0]       cap_m, lower, upper, span, den;
   logic [LEN_W+THR_W-1:0] num;
   logic                   cap_zero, below, above, mid;

   logic              accept, slot_free;
   logic              div_start, div_done, lcg_start, lcg_done, rsp_load;
   logic [THR_W-1:0]  quot;
   logic [SEED_W-1:0] lcg_seed;
   logic              csr_write, reg_sel;

   // configuration
   assign pready    = 1'b1;
   assign reg_sel   = paddr[CSR_AW-1];
   assign csr_write = psel && penable && pwrite;
   assign prdata    = (reg_sel == REG_QUEUE_CAPACITY) ? CSR_DW'(cap_ff) : '0;

   // threshold segment bounds
   always_comb begin
      cap_m    = cap_ff[LEN_W-1:0];
      lower    = cap_m >> LOWER_SHIFT;
      upper    = cap_m - (cap_m >> UPPER_SHIFT);
      cap_zero = (cap_m == '0);
      below    = (len_ff < lower);
      above    = (len_ff >= upper);
      mid      = !cap_zero && !below && !above;
      span     = len_ff - lower;
      den      = upper - lower;
      num      = {span, {THR_W{1'b0}}} - (LEN_W+THR_W)'(span);
   end

   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (op_ff == OP_UPDATE && mid) state_in = ST_DIV;
            else if (op_ff == OP_QUERY && !flag_ff) state_in = ST_LCG;
            else state_in = ST_FIN;
         end
         ST_DIV: begin
            if (div_done) state_in = ST_FIN;
         end
         ST_LCG: begin
            if (lcg_done) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      lcg_start = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_EXEC: begin
            div_start = (op_ff == OP_UPDATE) && mid;
            lcg_start = (op_ff == OP_QUERY) && !flag_ff;
         end
         ST_FIN:  rsp_load = slot_free;
         default: ;
      endcase
   end

   // policy state
   always_comb begin
      thr_in  = thr_ff;
      flag_in = flag_ff;
      seed_in = seed_ff;
      dec_in  = dec_ff;
      case (state_ff)
         ST_EXEC: begin
            dec_in = DEC_PASS;
            case (op_ff)
               OP_UPDATE: begin
                  if (cap_zero || above) begin
                     thr_in  = THR_MAX;
                     flag_in = 1'b1;
                  end else if (below) begin
                     thr_in  = '0;
                     flag_in = 1'b0;
                  end else begin
                     flag_in = 1'b0;
                  end
               end
               OP_QUERY: begin
                  if (flag_ff) dec_in = DEC_FULL;
               end
               OP_RESET: begin
                  thr_in  = '0;
                  flag_in = 1'b0;
               end
               default: ;
            endcase
         end
         ST_DIV: begin
            if (div_done) thr_in = quot;
         end
         ST_LCG: begin
            if (lcg_done) begin
               seed_in = lcg_seed;
               dec_in  = (lcg_seed[RAND_LSB +: THR_W] < thr_ff) ? DEC_PROB : DEC_PASS;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= '0;
         thr_ff       <= '0;
         flag_ff      <= 1'b0;
         seed_ff      <= SEED_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         thr_ff   <= thr_in;
         flag_ff  <= flag_in;
         seed_ff  <= seed_in;
         if (csr_write && reg_sel == REG_QUEUE_CAPACITY) cap_ff <= pwdata[CAP_W-1:0];
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
      dec_ff <= dec_in;
      if (accept) begin
         op_ff  <= req_word.op;
         len_ff <= req_word.queue_len[LEN_W-1:0];
      end
      if (rsp_load) begin
         rsp_word_ff <= '{decision: dec_ff, drop_threshold: thr_ff, drop_all: flag_ff};
      end
   end

   qred_div #(
      .W(LEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num),
      .den   (den),
      .done  (div_done),
      .quot  (quot)
   );

   qred_lcg u_lcg (
      .clock     (clock),
      .reset     (reset),
      .start     (lcg_start),
      .seed      (seed_ff),
      .done      (lcg_done),
      .next_seed (lcg_seed)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

/* hw/rtl/qred_checker.sv */
`include "queue_level_random_early_drop_assert.svh"

module qred_checker import qred_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_word_type rsp_word
);

   `QRED_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word), "rsp word dropped or changed while stalled")

   `QRED_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "second word taken while one is in work")

   `QRED_ASSERT_IMPL(a_full_at_max, rsp_valid && rsp_word.drop_all, rsp_word.drop_threshold == THR_MAX, "full drop without maximum threshold")

   `QRED_ASSERT_IMPL(a_full_decision, rsp_valid && rsp_word.decision == DEC_FULL, rsp_word.drop_all, "full-drop decision without full-drop flag")

endmodule

bind queue_level_random_early_drop qred_checker u_checker (.*);
